### design/delta_list_timer_queue_macros.svh
// Assertion macros for the timer queue
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define DLTQ_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define DLTQ_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define DLTQ_ASSERT_IMPL(label, clk, rst, prop)
`define DLTQ_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### design/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;
  localparam int EventSlotsDefault = 16;
  localparam int MaxResults = 16;

  localparam logic [1:0] KIND_CREATED  = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_EXPIRED  = 2'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CREATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_EXP_CHK,
    ST_EXP_OUT,
    ST_INS_HEAD,
    ST_INS_HCMP,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_INS_SUCC,
    ST_INS_FIN
  } state_t;
endpackage

### design/dltq_ram.sv
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer event queue kept as a sorted delta list in two RAMs.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the edge that accepts a request
// until its last result; a tick that expires nothing ends after its head
// delta write-back. A create answered rejected or pool full, and a tick
// on an empty queue, finish in the accept cycle without raising busy; the
// rejected and pool full results appear in that same cycle. A tick reads,
// then writes back the head delta, then per expired event reads the link,
// then the delta of the new head to set last. A create on an empty queue
// goes straight to its final write, one before the head after a compare
// with it, and otherwise walks the list, each step a registered read of
// the link and delta RAMs then a compare. Results come one per strobe and
// cannot be stalled. Slot numbers are the low four bits.
`include "delta_list_timer_queue_macros.svh"
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int EVENT_SLOTS = EventSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [31:0] ticks,
  input  logic        min_ticks_we,
  input  logic [15:0] min_ticks_wdata,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  event_slot,
  output logic        last
);
  localparam int SW = $clog2(EVENT_SLOTS) + 1;
  localparam int AW = $clog2(EVENT_SLOTS);
  localparam int CW = $clog2(MaxResults + 1);
  localparam logic [SW-1:0] NoSlot = SW'(EVENT_SLOTS);

  state_t state, state_next;
  logic [15:0]          min_ticks;
  logic [SW-1:0]        head_slot;
  logic [EVENT_SLOTS-1:0] slot_busy;
  logic [31:0]          req_ticks;
  logic [AW-1:0]        new_slot;
  logic [SW-1:0]        prev, next;
  logic [32:0]          etime;
  logic [CW-1:0]        exp_cnt;

  // RAM ports
  logic             link_we, delta_we;
  logic [AW-1:0]    link_waddr, delta_waddr, raddr;
  logic [SW-1:0]    link_wdata, link_rdata;
  logic [31:0]      delta_wdata, delta_rdata;

  dltq_ram #(.WIDTH(SW), .DEPTH(EVENT_SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(raddr), .rdata(link_rdata));
  dltq_ram #(.WIDTH(32), .DEPTH(EVENT_SLOTS)) u_delta (
    .clk(clk), .we(delta_we), .waddr(delta_waddr), .wdata(delta_wdata),
    .raddr(raddr), .rdata(delta_rdata));

  // lowest free slot
  logic [SW-1:0] free_slot;
  always_comb begin
    free_slot = NoSlot;
    for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) free_slot = SW'(i);
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);

  // walk compare: ticks > etime + delta[next]
  logic [32:0] esum, dcalc;
  logic        go_on;
  assign esum  = etime + {1'b0, delta_rdata};
  assign go_on = ({1'b0, req_ticks} > esum);
  always_comb begin
    dcalc = (etime <= {1'b0, req_ticks}) ? ({1'b0, req_ticks} - etime) : 33'd0;
    if (dcalc < {17'd0, min_ticks}) dcalc = 33'd0;
  end

  // last expiry of a tick: count reached, list ended or new head not due
  logic exp_last;
  assign exp_last = (exp_cnt == CW'(MaxResults)) || (head_slot == NoSlot) ||
                    (delta_rdata != 32'd0);

  // delta for tail insertion straight after the head
  function automatic logic [32:0] dcalc_h(input logic [31:0] hd);
    logic [32:0] d;
    d = ({1'b0, req_ticks} >= {1'b0, hd}) ? {1'b0, req_ticks - hd} : 33'd0;
    if (d < {17'd0, min_ticks}) d = 33'd0;
    return d;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_CREATE) begin
            if (free_slot != NoSlot && ticks != 32'd0) state_next = ST_INS_HEAD;
          end else if (head_slot != NoSlot) begin
            state_next = ST_TICK_RD;
          end
        end
      end
      ST_TICK_RD:  state_next = ST_TICK_WR;
      ST_TICK_WR: begin
        if (delta_rdata > 32'd1) state_next = ST_IDLE;
        else state_next = ST_EXP_CHK;
      end
      ST_EXP_CHK:  state_next = ST_EXP_OUT;
      ST_EXP_OUT:  state_next = exp_last ? ST_IDLE : ST_EXP_CHK;
      ST_INS_HEAD: state_next = (head_slot == NoSlot) ? ST_INS_FIN : ST_INS_HCMP;
      ST_INS_HCMP: begin
        if (req_ticks < delta_rdata) state_next = ST_INS_FIN;
        else if (link_rdata == NoSlot) state_next = ST_INS_SUCC;
        else state_next = ST_WALK_CMP;
      end
      ST_WALK_RD:  state_next = (next == NoSlot) ? ST_INS_SUCC : ST_WALK_CMP;
      ST_WALK_CMP: state_next = go_on ? ST_WALK_RD : ST_INS_SUCC;
      ST_INS_SUCC: state_next = ST_INS_FIN;
      ST_INS_FIN:  state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    link_we = 1'b0; delta_we = 1'b0;
    link_waddr = new_slot; delta_waddr = new_slot;
    link_wdata = NoSlot; delta_wdata = req_ticks;
    raddr = head_slot[AW-1:0];
    strobe = 1'b0; kind = KIND_CREATED; event_slot = 4'd0; last = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_CREATE) begin
          if (free_slot == NoSlot) begin
            strobe = 1'b1; kind = KIND_FULL;
          end else if (ticks == 32'd0) begin
            strobe = 1'b1; kind = KIND_REJECTED;
          end
        end
      end
      ST_TICK_WR: begin
        delta_we = 1'b1;
        delta_waddr = head_slot[AW-1:0];
        delta_wdata = (delta_rdata != 32'd0) ? delta_rdata - 32'd1 : 32'd0;
      end
      ST_EXP_CHK: raddr = link_rdata[AW-1:0];
      ST_EXP_OUT: begin
        strobe = 1'b1; kind = KIND_EXPIRED;
        event_slot = 4'(prev);
        last = exp_last;
      end
      ST_INS_HCMP: begin
        raddr = link_rdata[AW-1:0];
        if (req_ticks < delta_rdata) begin
          delta_we = 1'b1;
          delta_waddr = head_slot[AW-1:0];
          delta_wdata = delta_rdata - req_ticks;
        end
      end
      ST_WALK_RD: raddr = next[AW-1:0];
      ST_WALK_CMP: raddr = next[AW-1:0];
      ST_INS_SUCC: begin
        link_we = 1'b1;
        link_waddr = prev[AW-1:0];
        link_wdata = {1'b0, new_slot};
        if (next != NoSlot) begin
          delta_we = 1'b1;
          delta_waddr = next[AW-1:0];
          delta_wdata = ({1'b0, delta_rdata} >= etime) ? delta_rdata - etime[31:0] : 32'd0;
        end
      end
      ST_INS_FIN: begin
        link_we = 1'b1;
        delta_we = 1'b1;
        link_wdata = next;
        delta_wdata = etime[31:0];
        strobe = 1'b1; kind = KIND_CREATED; event_slot = 4'(new_slot);
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      min_ticks <= 16'd0;
      head_slot <= NoSlot;
      slot_busy <= '0;
    end else begin
      state <= state_next;
      if (min_ticks_we) min_ticks <= min_ticks_wdata;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_ticks <= ticks;
            new_slot  <= free_slot[AW-1:0];
            exp_cnt   <= '0;
          end
        end
        ST_EXP_CHK: begin
          prev <= head_slot;
          head_slot <= link_rdata;
          slot_busy[head_slot[AW-1:0]] <= 1'b0;
          exp_cnt <= exp_cnt + CW'(1);
        end
        ST_INS_HEAD: begin
          slot_busy[new_slot] <= 1'b1;
          if (head_slot == NoSlot) begin
            next <= NoSlot; etime <= {1'b0, req_ticks};
            head_slot <= {1'b0, new_slot};
          end
        end
        ST_INS_HCMP: begin
          if (req_ticks < delta_rdata) begin
            next <= head_slot; etime <= {1'b0, req_ticks};
            head_slot <= {1'b0, new_slot};
          end else begin
            prev <= head_slot;
            next <= link_rdata;
            if (link_rdata == NoSlot) begin
              etime <= dcalc_h(delta_rdata);
            end else begin
              etime <= {1'b0, delta_rdata};
            end
          end
        end
        ST_WALK_RD: begin
          if (next == NoSlot) etime <= dcalc;
        end
        ST_WALK_CMP: begin
          if (go_on) begin
            prev <= next; etime <= esum; next <= link_rdata;
          end else begin
            etime <= dcalc;
          end
        end
        default: ;
      endcase
    end
  end

  `DLTQ_ASSERT_NEVER(a_strobe_state, clk, rst, strobe && busy && state != ST_EXP_OUT && state != ST_INS_FIN)
  `DLTQ_ASSERT_IMPL(a_busy_hold, clk, rst, (state == ST_INS_FIN) |=> !busy)
  `DLTQ_ASSERT_IMPL(a_cnt_bound, clk, rst, (state == ST_EXP_CHK) |-> (exp_cnt < CW'(MaxResults)))
endmodule
